// ===== hdl/coe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator package
// Shared widths, codes, configuration record, controller states and the
// command and status records between the controller and the datapath.
// ----------------------------------------------------------------------------
package coe_pkg;

   localparam int TIME_W    = 47;  // unsigned Q31.16 time
   localparam int OFF_W     = 48;  // signed offset
   localparam int Q_W       = 30;  // smoothstep position and weight fraction
   localparam int DIV_CNT_W = 5;
   localparam int CSR_IDX_W = 3;
   localparam int BURST_W   = 4;

   // Sample ring depth and the width of the stored sample count.
   localparam int RING_DEPTH = 8;
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   // Result payload, padded to whole bytes.
   localparam int RSP_BITS   = 2 * OFF_W + TIME_W + 1 + CNT_W;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OP_RESPONSE = 2'd0,
      OP_SEED     = 2'd1,
      OP_MARK     = 2'd2,
      OP_QUERY    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_APPLIED   = 2'd0,
      ST_NEG_RTT   = 2'd1,
      ST_RTT_LIMIT = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_RTT        = 3'd0,
      REG_SLEW_TIME      = 3'd1,
      REG_BURST_SAMPLES  = 3'd2,
      REG_BURST_INTERVAL = 3'd3,
      REG_SYNC_INTERVAL  = 3'd4
   } reg_index_type;

   localparam logic [TIME_W-1:0]  MAX_RTT_RESET        = 47'd655360;
   localparam logic [TIME_W-1:0]  SLEW_TIME_RESET      = 47'd65536;
   localparam logic [BURST_W-1:0] BURST_SAMPLES_RESET  = 4'd5;
   localparam logic [TIME_W-1:0]  BURST_INTERVAL_RESET = 47'd13107;
   localparam logic [TIME_W-1:0]  SYNC_INTERVAL_RESET  = 47'd327680;

   typedef struct packed {
      logic [TIME_W-1:0]  max_rtt;
      logic [TIME_W-1:0]  slew_time;
      logic [BURST_W-1:0] burst_samples;
      logic [TIME_W-1:0]  burst_interval;
      logic [TIME_W-1:0]  sync_interval;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_OUT_ADDR,
      S_OUT_LOAD,
      S_INNER,
      S_SCAN_END,
      S_EFF_START,
      S_DIV,
      S_MUL_SQ,
      S_MUL_WT,
      S_MUL_HI,
      S_MUL_LO,
      S_EFF_SUM,
      S_COMMIT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic latch;
      logic decode;
      logic outer_addr;
      logic outer_load;
      logic inner;
      logic scan_end;
      logic eff_start;
      logic div_step;
      logic mul_sq;
      logic mul_wt;
      logic mul_hi;
      logic mul_lo;
      logic eff_sum;
      logic commit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic store_path;
      logic eff_fast;
      logic div_last;
      logic inner_last;
      logic outer_last;
      logic target_changed;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== hdl/coe_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator configuration registers
// Holds the five configuration registers written over the csr channel.
// ----------------------------------------------------------------------------
module coe_csr
   import coe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_MAX_RTT:        cfg_in.max_rtt        = csr_data;
            REG_SLEW_TIME:      cfg_in.slew_time      = csr_data;
            REG_BURST_SAMPLES:  cfg_in.burst_samples  = csr_data[BURST_W-1:0];
            REG_BURST_INTERVAL: cfg_in.burst_interval = csr_data;
            REG_SYNC_INTERVAL:  cfg_in.sync_interval  = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_rtt        <= MAX_RTT_RESET;
         cfg_ff.slew_time      <= SLEW_TIME_RESET;
         cfg_ff.burst_samples  <= BURST_SAMPLES_RESET;
         cfg_ff.burst_interval <= BURST_INTERVAL_RESET;
         cfg_ff.sync_interval  <= SYNC_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/coe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator controller
// Sequences decode, ring scan, slew evaluation and result hand-off.
// ----------------------------------------------------------------------------
module coe_ctrl
   import coe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   // Set while the slew is evaluated to restart it on a new target.
   logic      change_ff, change_in;

   always_comb begin
      state_in  = state_ff;
      change_in = change_ff;
      case (state_ff)
         S_IDLE:      if (req_tvalid) state_in = S_DECODE;
         S_DECODE:    state_in = dp_status.store_path ? S_OUT_ADDR : S_EFF_START;
         S_OUT_ADDR:  state_in = S_OUT_LOAD;
         S_OUT_LOAD:  state_in = S_INNER;
         S_INNER: begin
            if (dp_status.inner_last) begin
               state_in = dp_status.outer_last ? S_SCAN_END : S_OUT_ADDR;
            end
         end
         S_SCAN_END: begin
            state_in  = S_EFF_START;
            change_in = dp_status.target_changed;
         end
         S_EFF_START: begin
            if (dp_status.eff_fast) begin
               state_in = change_ff ? S_COMMIT : S_RESULT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV:       if (dp_status.div_last) state_in = S_MUL_SQ;
         S_MUL_SQ:    state_in = S_MUL_WT;
         S_MUL_WT:    state_in = S_MUL_HI;
         S_MUL_HI:    state_in = S_MUL_LO;
         S_MUL_LO:    state_in = S_EFF_SUM;
         S_EFF_SUM:   state_in = change_ff ? S_COMMIT : S_RESULT;
         S_COMMIT: begin
            state_in  = S_EFF_START;
            change_in = 1'b0;
         end
         S_RESULT:    if (dp_status.rsp_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_tready     = (state_ff == S_IDLE);
      cmd.latch      = (state_ff == S_IDLE) && req_tvalid;
      cmd.decode     = (state_ff == S_DECODE);
      cmd.outer_addr = (state_ff == S_OUT_ADDR);
      cmd.outer_load = (state_ff == S_OUT_LOAD);
      cmd.inner      = (state_ff == S_INNER);
      cmd.scan_end   = (state_ff == S_SCAN_END);
      cmd.eff_start  = (state_ff == S_EFF_START);
      cmd.div_step   = (state_ff == S_DIV);
      cmd.mul_sq     = (state_ff == S_MUL_SQ);
      cmd.mul_wt     = (state_ff == S_MUL_WT);
      cmd.mul_hi     = (state_ff == S_MUL_HI);
      cmd.mul_lo     = (state_ff == S_MUL_LO);
      cmd.eff_sum    = (state_ff == S_EFF_SUM);
      cmd.commit     = (state_ff == S_COMMIT);
      cmd.load_rsp   = (state_ff == S_RESULT) && dp_status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         change_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         change_ff <= change_in;
      end
   end

endmodule

// ===== hdl/coe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator datapath
// Sample ring, minimum and median scan, serial divider, shared multiplier
// for the smoothstep slew and the result register.
// ----------------------------------------------------------------------------
module coe_dp
   import coe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output dp_status_type     dp_status,
   input  cfg_type           cfg,
   input  logic [1:0]        in_opcode,
   input  logic [TIME_W-1:0] in_now_time,
   input  logic [TIME_W-1:0] in_send_time,
   input  logic [TIME_W-1:0] in_server_stamp,
   input  logic [OFF_W-1:0]  in_seed_offset,
   input  logic [OFF_W-1:0]  in_seed_rtt,
   input  logic              rsp_tready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [OFF_W-1:0]  rsp_server_now,
   output logic              rsp_send_due,
   output logic [OFF_W-1:0]  rsp_target_offset,
   output logic [TIME_W-1:0] rsp_median_rtt,
   output logic [CNT_W-1:0]  rsp_stored_count
);

   localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int ENT_W  = OFF_W + TIME_W;
   localparam int CMP_W  = (CNT_W > BURST_W) ? CNT_W : BURST_W;
   localparam logic [OFF_W-1:0] S48_MAX = {1'b0, {(OFF_W-1){1'b1}}};
   localparam logic [OFF_W-1:0] S48_MIN = {1'b1, {(OFF_W-1){1'b0}}};
   localparam logic [31:0] THREE_Q30 = 32'(3) << Q_W;

   // Latched item.
   opcode_type        op_ff;
   logic [TIME_W-1:0] now_ff, send_ff, server_ff;
   logic [OFF_W-1:0]  seed_off_ff, seed_rtt_ff;

   // Estimator state.
   logic [SLOT_W-1:0] write_slot_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [OFF_W-1:0]  adopted_ff, prev_ff;
   logic [TIME_W-1:0] change_ff, typical_ff, last_sent_ff;
   logic              seed_flag_ff, never_sent_ff;
   status_type        status_ff;

   // Ring memory.
   logic [ENT_W-1:0]  ring_mem [RING_DEPTH];
   logic [ENT_W-1:0]  rd_ff;
   logic [CNT_W-1:0]  rd_idx;

   // Scan.
   logic [CNT_W-1:0]  i_ff, j_ff, less_ff, leq_ff;
   logic [TIME_W-1:0] outer_rtt_ff, best_rtt_ff, med_lo_ff, med_hi_ff;
   logic [OFF_W-1:0]  best_off_ff;

   // Slew.
   logic [TIME_W-1:0]    rem_ff;
   logic [Q_W-1:0]       u_ff, sq_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [31:0]          wt_ff;
   logic [56:0]          hi_prod_ff;
   logic [55:0]          lo_prod_ff;
   logic [OFF_W-1:0]     eff_ff;

   // Result register.
   logic              rsp_valid_ff, rsp_due_ff;
   logic [1:0]        rsp_status_ff;
   logic [OFF_W-1:0]  rsp_server_ff, rsp_target_ff;
   logic [TIME_W-1:0] rsp_median_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   // ---------------- decode ----------------
   logic [OFF_W-1:0]  rtt_s;
   logic              rtt_neg, rtt_over, store_path, seed_op, do_write;
   logic [OFF_W+1:0]  off_wide;
   logic [OFF_W-1:0]  off_sat, wr_off;
   logic [TIME_W-1:0] wr_rtt, seed_rtt_clamp;
   logic [SLOT_W-1:0] wr_slot, slot_next;
   logic [CNT_W-1:0]  base_cnt, cnt_next;

   always_comb begin
      rtt_s    = {1'b0, now_ff} - {1'b0, send_ff};
      rtt_neg  = rtt_s[OFF_W-1];
      rtt_over = !rtt_neg && (rtt_s[TIME_W-1:0] > cfg.max_rtt);
      store_path = (op_ff == OP_RESPONSE) && !rtt_neg && !rtt_over;
      seed_op  = (op_ff == OP_SEED);
      do_write = store_path || seed_op;
      off_wide = {3'b000, server_ff} + {4'b0000, rtt_s[TIME_W-1:1]} - {3'b000, now_ff};
      if (off_wide[OFF_W+1:OFF_W-1] == 3'b000 || off_wide[OFF_W+1:OFF_W-1] == 3'b111) begin
         off_sat = off_wide[OFF_W-1:0];
      end else if (off_wide[OFF_W+1]) begin
         off_sat = S48_MIN;
      end else begin
         off_sat = S48_MAX;
      end
      seed_rtt_clamp = seed_rtt_ff[OFF_W-1] ? '0 : seed_rtt_ff[TIME_W-1:0];
      wr_off  = seed_op ? seed_off_ff : off_sat;
      wr_rtt  = seed_op ? seed_rtt_clamp : rtt_s[TIME_W-1:0];
      wr_slot = (seed_op || seed_flag_ff) ? '0 : write_slot_ff;
      slot_next = (wr_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
      base_cnt  = (seed_op || seed_flag_ff) ? '0 : count_ff;
      cnt_next  = (base_cnt == CNT_W'(RING_DEPTH)) ? base_cnt : base_cnt + 1'b1;
   end

   // ---------------- ring ----------------
   always_comb begin
      rd_idx = i_ff;
      if (cmd.outer_load) rd_idx = '0;
      else if (cmd.inner) rd_idx = j_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.decode && do_write) begin
         ring_mem[wr_slot] <= {wr_off, wr_rtt};
      end
      rd_ff <= ring_mem[rd_idx[SLOT_W-1:0]];
   end

   logic [OFF_W-1:0]  rd_off;
   logic [TIME_W-1:0] rd_rtt;
   logic [CNT_W-1:0]  less_in, leq_in, k_lo, k_hi;
   logic              inner_last;
   logic [TIME_W:0]   med_sum;

   always_comb begin
      rd_off  = rd_ff[ENT_W-1:TIME_W];
      rd_rtt  = rd_ff[TIME_W-1:0];
      less_in = less_ff + CNT_W'(rd_rtt < outer_rtt_ff);
      leq_in  = leq_ff + CNT_W'(rd_rtt <= outer_rtt_ff);
      k_lo    = (count_ff - 1'b1) >> 1;
      k_hi    = count_ff >> 1;
      inner_last = (j_ff == count_ff);
      med_sum = {1'b0, med_lo_ff} + {1'b0, med_hi_ff};
   end

   // ---------------- slew ----------------
   logic [OFF_W-1:0] dt;
   logic             ge_slew, le_zero, same_off, eff_fast, d_neg;
   logic [OFF_W:0]   d_wide, mag;
   logic [TIME_W:0]  r2;
   logic             r_ge;
   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul_p;
   logic [57:0]      psum;
   logic [OFF_W:0]   part;
   logic [OFF_W+1:0] eff_sum;

   always_comb begin
      dt       = {1'b0, now_ff} - {1'b0, change_ff};
      ge_slew  = $signed(dt) >= $signed({1'b0, cfg.slew_time});
      le_zero  = dt[OFF_W-1] || (dt == '0);
      same_off = (prev_ff == adopted_ff);
      eff_fast = same_off || ge_slew || le_zero;
      d_wide   = {adopted_ff[OFF_W-1], adopted_ff} - {prev_ff[OFF_W-1], prev_ff};
      d_neg    = d_wide[OFF_W];
      mag      = d_neg ? (~d_wide + 1'b1) : d_wide;
      r2       = {rem_ff, 1'b0};
      r_ge     = r2 >= {1'b0, cfg.slew_time};
      mul_a = {2'b00, u_ff};
      mul_b = {2'b00, u_ff};
      if (cmd.mul_wt) begin
         mul_a = {2'b00, sq_ff};
         mul_b = THREE_Q30 - {1'b0, u_ff, 1'b0};
      end else if (cmd.mul_hi) begin
         mul_a = {7'd0, mag[OFF_W:24]};
         mul_b = wt_ff;
      end else if (cmd.mul_lo) begin
         mul_a = {8'd0, mag[23:0]};
         mul_b = wt_ff;
      end
      mul_p = mul_a * mul_b;
      psum  = {1'b0, hi_prod_ff} + {26'd0, lo_prod_ff[55:24]};
      part  = psum[OFF_W+6:6];
      eff_sum = d_neg ? ({prev_ff[OFF_W-1], prev_ff[OFF_W-1], prev_ff} - {1'b0, part})
                      : ({prev_ff[OFF_W-1], prev_ff[OFF_W-1], prev_ff} + {1'b0, part});
   end

   // ---------------- result ----------------
   logic [OFF_W:0]    srv_wide;
   logic [OFF_W-1:0]  srv_sat, since_sent;
   logic [CNT_W-1:0]  real_cnt;
   logic [TIME_W-1:0] interval;
   logic              due, rsp_free;

   always_comb begin
      srv_wide = {2'b00, now_ff} + {eff_ff[OFF_W-1], eff_ff};
      if (srv_wide[OFF_W] == srv_wide[OFF_W-1]) srv_sat = srv_wide[OFF_W-1:0];
      else if (srv_wide[OFF_W]) srv_sat = S48_MIN;
      else srv_sat = S48_MAX;
      real_cnt   = seed_flag_ff ? '0 : count_ff;
      interval   = (CMP_W'(real_cnt) < CMP_W'(cfg.burst_samples)) ? cfg.burst_interval
                                                                : cfg.sync_interval;
      since_sent = {1'b0, now_ff} - {1'b0, last_sent_ff};
      due        = never_sent_ff || ($signed(since_sent) >= $signed({1'b0, interval}));
      rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      dp_status.store_path     = store_path;
      dp_status.eff_fast       = eff_fast;
      dp_status.div_last       = (div_cnt_ff == DIV_CNT_W'(Q_W - 1));
      dp_status.inner_last     = inner_last;
      dp_status.outer_last     = (i_ff == count_ff - 1'b1);
      dp_status.target_changed = (best_off_ff != adopted_ff);
      dp_status.rsp_free       = rsp_free;
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff       <= opcode_type'(in_opcode);
         now_ff      <= in_now_time;
         send_ff     <= in_send_time;
         server_ff   <= in_server_stamp;
         seed_off_ff <= in_seed_offset;
         seed_rtt_ff <= in_seed_rtt;
      end
      if (cmd.decode) begin
         i_ff <= '0;
      end
      if (cmd.outer_load) begin
         outer_rtt_ff <= rd_rtt;
         less_ff      <= '0;
         leq_ff       <= '0;
         j_ff         <= CNT_W'(1);
         if (i_ff == '0 || rd_rtt < best_rtt_ff) begin
            best_rtt_ff <= rd_rtt;
            best_off_ff <= rd_off;
         end
      end
      if (cmd.inner) begin
         less_ff <= less_in;
         leq_ff  <= leq_in;
         j_ff    <= j_ff + 1'b1;
         if (inner_last) begin
            i_ff <= i_ff + 1'b1;
            if (less_in <= k_lo && k_lo < leq_in) med_lo_ff <= outer_rtt_ff;
            if (less_in <= k_hi && k_hi < leq_in) med_hi_ff <= outer_rtt_ff;
         end
      end
      if (cmd.eff_start) begin
         if (eff_fast) eff_ff <= (same_off || ge_slew) ? adopted_ff : prev_ff;
         rem_ff     <= dt[TIME_W-1:0];
         u_ff       <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= r_ge ? TIME_W'(r2 - {1'b0, cfg.slew_time}) : r2[TIME_W-1:0];
         u_ff       <= {u_ff[Q_W-2:0], r_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.mul_sq) sq_ff <= mul_p[2*Q_W-1:Q_W];
      if (cmd.mul_wt) wt_ff <= mul_p[Q_W+31:Q_W];
      if (cmd.mul_hi) hi_prod_ff <= mul_p[56:0];
      if (cmd.mul_lo) lo_prod_ff <= mul_p[55:0];
      if (cmd.eff_sum) eff_ff <= eff_sum[OFF_W-1:0];
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_server_ff <= srv_sat;
         rsp_due_ff    <= due;
         rsp_target_ff <= adopted_ff;
         rsp_median_ff <= typical_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   // Control state of the estimator.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         count_ff      <= '0;
         adopted_ff    <= '0;
         prev_ff       <= '0;
         change_ff     <= '0;
         typical_ff    <= '0;
         seed_flag_ff  <= 1'b0;
         last_sent_ff  <= '0;
         never_sent_ff <= 1'b1;
         status_ff     <= ST_APPLIED;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.decode) begin
            if (op_ff == OP_RESPONSE && rtt_neg) status_ff <= ST_NEG_RTT;
            else if (op_ff == OP_RESPONSE && rtt_over) status_ff <= ST_RTT_LIMIT;
            else status_ff <= ST_APPLIED;
            if (do_write) begin
               write_slot_ff <= slot_next;
               count_ff      <= cnt_next;
            end
            if (store_path) seed_flag_ff <= 1'b0;
            if (seed_op) begin
               adopted_ff   <= seed_off_ff;
               prev_ff      <= seed_off_ff;
               change_ff    <= '0;
               typical_ff   <= seed_rtt_clamp;
               seed_flag_ff <= 1'b1;
            end
            if (op_ff == OP_MARK) begin
               last_sent_ff  <= now_ff;
               never_sent_ff <= 1'b0;
            end
         end
         if (cmd.scan_end) typical_ff <= med_sum[TIME_W:1];
         if (cmd.commit) begin
            prev_ff    <= eff_ff;
            change_ff  <= now_ff;
            adopted_ff <= best_off_ff;
         end
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_server_now    = rsp_server_ff;
   assign rsp_send_due      = rsp_due_ff;
   assign rsp_target_offset = rsp_target_ff;
   assign rsp_median_rtt    = rsp_median_ff;
   assign rsp_stored_count  = rsp_count_ff;

endmodule

// ===== hdl/clock_offset_min_delay_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator with minimum-delay sample selection
// Keeps a ring of round trip samples, adopts the offset of the fastest one,
// reports the median round trip and slews the server time with smoothstep.
// ----------------------------------------------------------------------------
// Usage. Each req transaction carries one item: the opcode in req_tuser and
// the times in req_tdata. Every item yields exactly one rsp transaction with
// the status in rsp_tuser and the server time, send hint and estimates in
// rsp_tdata. Configuration registers are written on the csr channel, which is
// always ready; the user must write them only while no item is in flight,
// and the block itself does not enforce this.
// Timing. Items are handled one at a time. A query, mark, seed or rejected
// response skips the slew evaluation when no slew is running and otherwise
// needs the 30-step serial divider and the four passes through the shared
// multiplier. An accepted response adds a scan of the sample ring through
// its single read port, plus a commit that restarts the slew when the adopted
// offset changes. A new item is taken in the cycle after the previous result
// is placed in the output register.
// Reset clears the ring count, the estimates and the send history; the ring
// contents themselves are not cleared. If the receiver stalls, the result
// waits in the output register and the next item is still accepted, but
// its result is held back until the register is free.
// ----------------------------------------------------------------------------
module clock_offset_min_delay_estimator
   import coe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // now_time[46:0], send_time[93:47], server_stamp[140:94],
   // seed_offset[188:141], seed_rtt[236:189], zero fill above
   input  logic [239:0]         req_tdata,
   // opcode[1:0]
   input  logic [1:0]           req_tuser,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // server_now[47:0], send_due[48], target_offset[96:49],
   // median_rtt[143:97], stored_count[147:144], zero fill above
   output logic [RSP_W-1:0]     rsp_tdata,
   // status[1:0]
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_data
);

   cfg_type       cfg;
   cmd_type       cmd;
   dp_status_type dp_status;

   logic [OFF_W-1:0]  rsp_server_now, rsp_target_offset;
   logic [TIME_W-1:0] rsp_median_rtt;
   logic [CNT_W-1:0]  rsp_stored_count;
   logic              rsp_send_due;

   coe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   coe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   coe_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .cfg               (cfg),
      .in_opcode         (req_tuser),
      .in_now_time       (req_tdata[46:0]),
      .in_send_time      (req_tdata[93:47]),
      .in_server_stamp   (req_tdata[140:94]),
      .in_seed_offset    (req_tdata[188:141]),
      .in_seed_rtt       (req_tdata[236:189]),
      .rsp_tready        (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_status        (rsp_tuser),
      .rsp_server_now    (rsp_server_now),
      .rsp_send_due      (rsp_send_due),
      .rsp_target_offset (rsp_target_offset),
      .rsp_median_rtt    (rsp_median_rtt),
      .rsp_stored_count  (rsp_stored_count)
   );

   // Result fields packed from the lowest bit up.
   assign rsp_tdata = RSP_W'({rsp_stored_count, rsp_median_rtt, rsp_target_offset,
                              rsp_send_due, rsp_server_now});

endmodule

// ===== test/tb_clock_offset_min_delay_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator testbench
// Drives sync responses, seeds, send marks and queries through the request
// stream under several register settings, recomputes every result with an
// independent model of the sample ring, minimum-delay selection, median and
// smoothstep slew, and compares each response transaction field by field.
// ----------------------------------------------------------------------------
module tb_clock_offset_min_delay_estimator;
   import coe_pkg::*;

   localparam logic [46:0] T_MAX = 47'h7FFF_FFFF_FFFF;
   localparam longint S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint S48_LO = -64'sh0000_8000_0000_0000;
   localparam int RANDOM_PER_PHASE = 435;
   localparam int IDLE_LIMIT = 20000;

   // One request item, as the fields of req_tuser and req_tdata.
   typedef struct {
      opcode_type  op;
      logic [46:0] now;
      logic [46:0] send;
      logic [46:0] server;
      logic [47:0] seed_off;
      logic [47:0] seed_rtt;
   } sync_item_t;

   // One result item, as the fields of rsp_tuser and rsp_tdata.
   typedef struct {
      status_type  status;
      logic [47:0] server_now;
      logic        send_due;
      logic [47:0] target;
      logic [46:0] median;
      logic [3:0]  count;
   } estimate_t;

   typedef struct {
      sync_item_t item;
      bit         typed;   // the expectation below is typed in by hand
      estimate_t  want;
   } dir_row_t;

   logic         clock;
   logic         reset;
   logic [239:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         req_tvalid;
   logic         req_tready;
   logic [151:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [46:0]  csr_data;

   clock_offset_min_delay_estimator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Estimator model: its own ring, selection state and register copies.
   // ------------------------------------------------------------------------
   longint ring_off [8];
   longint ring_rtt [8];
   int     next_slot;
   int     n_samples;
   longint target_off;
   longint start_off;      // offset the running slew starts from
   longint slew_anchor;    // local time at which the slew started
   longint median_est;
   bit     seeded;
   longint sent_at;
   bit     unsent;
   longint lim_rtt, slew_len, warm_samples, warm_gap, steady_gap;

   estimate_t expected_estimates [$];
   int        errors;
   int        results_seen;
   int        idle_cycles;

   function automatic longint sat48(longint v);
      if (v > S48_HI) return S48_HI;
      if (v < S48_LO) return S48_LO;
      return v;
   endfunction

   // Offset in effect at local time t: smoothstep blend from start_off to
   // target_off over slew_len, in Q0.30 steps.
   function automatic longint slewed_offset(longint t);
      longint dt, d;
      longint unsigned rem, pos, pos_sq, weight, mag, part;
      if (start_off == target_off) return target_off;
      dt = t - slew_anchor;
      if (dt >= slew_len) return target_off;
      if (dt <= 0) return start_off;
      rem = dt;
      pos = 0;
      for (int i = 0; i < 30; i++) begin
         rem = rem << 1;
         pos = pos << 1;
         if (rem >= longint'(slew_len)) begin
            rem = rem - slew_len;
            pos = pos | 1;
         end
      end
      pos_sq = (pos * pos) >> 30;
      weight = (pos_sq * ((64'd3 << 30) - 2 * pos)) >> 30;
      d = target_off - start_off;
      mag = (d < 0) ? -d : d;
      part = (((mag >> 24) * weight) + (((mag & 64'hFF_FFFF) * weight) >> 24)) >> 6;
      return (d < 0) ? start_off - longint'(part) : start_off + longint'(part);
   endfunction

   // Puts one sample into the ring, then reselects the fastest sample and
   // recomputes the median round trip.
   function automatic void add_sample(longint off, longint rtt, longint t);
      longint sorted [8];
      longint v;
      int best, j;
      ring_off[next_slot] = off;
      ring_rtt[next_slot] = rtt;
      next_slot = (next_slot + 1) % 8;
      if (n_samples < 8) n_samples++;
      best = 0;
      for (int i = 1; i < n_samples; i++)
         if (ring_rtt[i] < ring_rtt[best]) best = i;
      if (ring_off[best] != target_off) begin
         start_off = slewed_offset(t);
         slew_anchor = t;
         target_off = ring_off[best];
      end
      for (int i = 0; i < n_samples; i++) begin
         v = ring_rtt[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      if (n_samples[0])
         median_est = sorted[n_samples/2];
      else
         median_est = (sorted[n_samples/2 - 1] + sorted[n_samples/2]) / 2;
   endfunction

   function automatic estimate_t predict_estimate(sync_item_t it);
      estimate_t e;
      longint t, rtt, gap;
      t = longint'({17'd0, it.now});
      e.status = ST_APPLIED;
      case (it.op)
         OP_RESPONSE: begin
            rtt = t - longint'({17'd0, it.send});
            if (rtt < 0) begin
               e.status = ST_NEG_RTT;
            end else if (rtt > lim_rtt) begin
               e.status = ST_RTT_LIMIT;
            end else begin
               // The first real sample after a seed throws the seed away.
               if (seeded) begin
                  next_slot = 0;
                  n_samples = 0;
                  seeded = 0;
               end
               add_sample(sat48(longint'({17'd0, it.server}) + (rtt >>> 1) - t), rtt, t);
            end
         end
         OP_SEED: begin
            rtt = longint'($signed(it.seed_rtt));
            if (rtt < 0) rtt = 0;
            next_slot = 0;
            n_samples = 0;
            add_sample(longint'($signed(it.seed_off)), rtt, 0);
            // A seed jumps straight to its offset, with no slew.
            start_off = target_off;
            slew_anchor = 0;
            seeded = 1;
         end
         OP_MARK: begin
            sent_at = t;
            unsent = 0;
         end
         default: ;
      endcase
      gap = ((seeded ? 0 : n_samples) < warm_samples) ? warm_gap : steady_gap;
      e.send_due   = unsent || ((t - sent_at) >= gap);
      e.server_now = 48'(sat48(t + slewed_offset(t)));
      e.target     = 48'(target_off);
      e.median     = 47'(median_est);
      e.count      = 4'(n_samples);
      return e;
   endfunction

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------
   bit     send_gaps;
   longint cur_now;
   longint phase_off;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offers one item and returns once it is accepted. tvalid stays high so
   // that a back-to-back item simply replaces the data.
   task automatic send_item(sync_item_t it, bit typed, estimate_t want);
      estimate_t e;
      int gap;
      gap = send_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {3'd0, it.seed_rtt, it.seed_off, it.server, it.send, it.now};
      do @(posedge clock); while (!req_tready);
      e = predict_estimate(it);
      expected_estimates.push_back(typed ? want : e);
   endtask

   task automatic csr_write(reg_index_type idx, longint value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 47'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MAX_RTT:        lim_rtt      = value;
         REG_SLEW_TIME:      slew_len     = value;
         REG_BURST_SAMPLES:  warm_samples = value;
         REG_BURST_INTERVAL: warm_gap     = value;
         REG_SYNC_INTERVAL:  steady_gap   = value;
         default: ;
      endcase
   endtask

   // Sender pause: every outstanding transaction drains, then the block is
   // given time to settle before registers may change.
   task automatic drain();
      req_tvalid <= 1'b0;
      wait (expected_estimates.size() == 0);
      repeat (250) @(posedge clock);
   endtask

   function automatic logic [46:0] rand47();
      return 47'({$urandom, $urandom});
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   // Mostly well-formed traffic on a moving local clock, plus raw noise.
   function automatic sync_item_t random_item();
      sync_item_t it;
      longint rtt, cap, srv;
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         it.op       = opcode_type'($urandom_range(0, 3));
         it.now      = rand47();
         it.send     = rand47();
         it.server   = rand47();
         it.seed_off = rand48();
         it.seed_rtt = rand48();
         return it;
      end
      cur_now += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1 << 20)
                                             : $urandom_range(0, 1 << 13);
      it.now      = 47'(cur_now);
      it.send     = rand47();
      it.server   = rand47();
      it.seed_off = 48'(longint'($signed($urandom)));
      it.seed_rtt = 48'(longint'($signed($urandom_range(0, 1 << 20))) - 1000);
      if (r < 55) begin
         it.op = OP_RESPONSE;
         cap = (lim_rtt > (1 << 20)) ? (1 << 20) : lim_rtt;
         case ($urandom_range(0, 9))
            0: rtt = 0;
            1: rtt = cap;
            2: rtt = cap + $urandom_range(1, 5000);
            3: rtt = -longint'($urandom_range(1, 100));
            default: rtt = $urandom_range(0, 32'(cap));
         endcase
         it.send = 47'(cur_now - rtt);
         srv = cur_now + phase_off + $urandom_range(0, 4000) - (rtt >>> 1);
         it.server = 47'(srv < 0 ? 0 : srv);
      end else if (r < 70) begin
         it.op = OP_MARK;
      end else if (r < 95) begin
         it.op = OP_QUERY;
      end else begin
         it.op = OP_SEED;
      end
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random back-pressure, one long hold-off in the middle
   // of the run, and stretches of constant readiness.
   // ------------------------------------------------------------------------
   int  hold_left;
   bit  hold_done;

   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      hold_done  = 0;
      forever begin
         @(posedge clock);
         if (!hold_done && results_seen >= 900) begin
            hold_done = 1;
            hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if ((results_seen / 200) % 3 == 1) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= (pick_gap() == 0);
         end
      end
   end

   // Checker: each response transaction against the oldest expectation.
   always @(posedge clock) begin
      estimate_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_estimates.size() == 0) begin
            $error("response transaction with no item outstanding");
            errors++;
         end else begin
            want = expected_estimates.pop_front();
            if (rsp_tuser != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[47:0] != want.server_now) begin
               $error("server_now: expected %0h, got %0h", want.server_now,
                      rsp_tdata[47:0]);
               errors++;
            end
            if (rsp_tdata[48] != want.send_due) begin
               $error("send_due: expected %0d, got %0d", want.send_due, rsp_tdata[48]);
               errors++;
            end
            if (rsp_tdata[96:49] != want.target) begin
               $error("target_offset: expected %0h, got %0h", want.target,
                      rsp_tdata[96:49]);
               errors++;
            end
            if (rsp_tdata[143:97] != want.median) begin
               $error("median_rtt: expected %0h, got %0h", want.median,
                      rsp_tdata[143:97]);
               errors++;
            end
            if (rsp_tdata[147:144] != want.count) begin
               $error("stored_count: expected %0d, got %0d", want.count,
                      rsp_tdata[147:144]);
               errors++;
            end
         end
      end
   end

   // Watchdog: too long without any transaction on either stream ends the
   // run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      dir_row_t  dir_table [$];
      sync_item_t it;
      estimate_t  none;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      errors      = 0;
      results_seen = 0;
      idle_cycles = 0;
      send_gaps   = 1'b1;

      // Model state after reset, registers at their reset values.
      next_slot = 0;  n_samples = 0;  target_off = 0;  start_off = 0;
      slew_anchor = 0;  median_est = 0;  seeded = 0;  sent_at = 0;  unsent = 1;
      lim_rtt = 655360;  slew_len = 65536;  warm_samples = 5;
      warm_gap = 13107;  steady_gap = 327680;
      none = '{ST_APPLIED, 48'd0, 1'b0, 48'd0, 47'd0, 4'd0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Only the first rows carry hand-written results: an
      // empty estimator reports the local time and asks for a request.
      dir_table.push_back('{'{OP_QUERY, 47'd1000, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b1,
                            '{ST_APPLIED, 48'd1000, 1'b1, 48'd0, 47'd0, 4'd0}});
      // Send time after the local time: negative round trip.
      dir_table.push_back('{'{OP_RESPONSE, 47'd1000, 47'd1001, 47'd5, 48'd0, 48'd0},
                            1'b1, '{ST_NEG_RTT, 48'd1000, 1'b1, 48'd0, 47'd0, 4'd0}});
      // Round trip well above the reset limit.
      dir_table.push_back('{'{OP_RESPONSE, 47'd2000000, 47'd0, 47'd9, 48'd0, 48'd0},
                            1'b1, '{ST_RTT_LIMIT, 48'd2000000, 1'b1, 48'd0, 47'd0, 4'd0}});
      dir_table.push_back('{'{OP_MARK, 47'd2000000, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      dir_table.push_back('{'{OP_RESPONSE, 47'd2000100, 47'd2000000, 47'd5000000, 48'd0,
                              48'd0}, 1'b0, none});
      // Mid-slew query.
      dir_table.push_back('{'{OP_QUERY, 47'd2020000, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      // Faster sample: new target while the first slew still runs.
      dir_table.push_back('{'{OP_RESPONSE, 47'd2030000, 47'd2029990, 47'd4000000, 48'd0,
                              48'd0}, 1'b0, none});
      // Round trip exactly at the limit, then zero round trip.
      dir_table.push_back('{'{OP_RESPONSE, 47'd3000000, 47'd2344640, 47'd3100000, 48'd0,
                              48'd0}, 1'b0, none});
      dir_table.push_back('{'{OP_RESPONSE, 47'd3000010, 47'd3000010, 47'd3000000, 48'd0,
                              48'd0}, 1'b0, none});
      dir_table.push_back('{'{OP_QUERY, 47'd3100000, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      // Extreme times: very negative and very positive offsets, tie on rtt.
      dir_table.push_back('{'{OP_RESPONSE, T_MAX, T_MAX - 47'd100, 47'd0, 48'd0, 48'd0},
                            1'b0, none});
      dir_table.push_back('{'{OP_RESPONSE, 47'd0, 47'd0, T_MAX, 48'd0, 48'd0}, 1'b0, none});
      dir_table.push_back('{'{OP_QUERY, T_MAX, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      // Seed with the most negative offset and a negative round trip.
      dir_table.push_back('{'{OP_SEED, 47'd10, 47'd0, 47'd0, 48'h8000_0000_0000,
                              48'hFFFF_FFFF_FFFF}, 1'b0, none});
      dir_table.push_back('{'{OP_QUERY, 47'd0, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      // Seed with the largest offset and round trip: server time saturates.
      dir_table.push_back('{'{OP_SEED, 47'd20, 47'd0, 47'd0, 48'h7FFF_FFFF_FFFF,
                              48'h7FFF_FFFF_FFFF}, 1'b0, none});
      dir_table.push_back('{'{OP_QUERY, T_MAX, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      // First real response after a seed empties the ring.
      dir_table.push_back('{'{OP_RESPONSE, 47'd5000, 47'd4990, 47'd9000, 48'd0, 48'd0},
                            1'b0, none});
      // Send hint around the burst interval.
      dir_table.push_back('{'{OP_MARK, 47'd5000, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      dir_table.push_back('{'{OP_QUERY, 47'd18106, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      dir_table.push_back('{'{OP_QUERY, 47'd18107, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});
      // Local time behind the last mark.
      dir_table.push_back('{'{OP_QUERY, 47'd100, 47'd0, 47'd0, 48'd0, 48'd0}, 1'b0, none});

      foreach (dir_table[i])
         send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);

      // Random phases, each under its own register setting. The first runs
      // at reset values; the next two take the extremes.
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            1: begin
               csr_write(REG_MAX_RTT, T_MAX);
               csr_write(REG_SLEW_TIME, 1);
               csr_write(REG_BURST_SAMPLES, 0);
               csr_write(REG_BURST_INTERVAL, 0);
               csr_write(REG_SYNC_INTERVAL, T_MAX);
            end
            2: begin
               csr_write(REG_MAX_RTT, 0);
               csr_write(REG_SLEW_TIME, T_MAX);
               csr_write(REG_BURST_SAMPLES, 8);
               csr_write(REG_BURST_INTERVAL, T_MAX);
               csr_write(REG_SYNC_INTERVAL, 0);
            end
            3: begin
               csr_write(REG_MAX_RTT, $urandom_range(1000, 1 << 20));
               csr_write(REG_SLEW_TIME, $urandom_range(1, 1 << 18));
               csr_write(REG_BURST_SAMPLES, $urandom_range(0, 8));
               csr_write(REG_BURST_INTERVAL, $urandom_range(0, 1 << 16));
               csr_write(REG_SYNC_INTERVAL, $urandom_range(0, 1 << 19));
            end
            default: ;
         endcase
         if (phase != 0) csr_valid <= 1'b0;
         cur_now   = longint'(1 << 22) + $urandom_range(0, 1 << 30);
         phase_off = longint'($signed($urandom_range(0, 1 << 21))) - (1 << 20);
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            // No sender gaps in one stretch of every phase.
            send_gaps = !(k >= 150 && k < 250);
            it = random_item();
            send_item(it, 1'b0, none);
         end
      end

      req_tvalid <= 1'b0;
      wait (expected_estimates.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_estimates.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
